// ===== design/fmmu_pkg.sv =====
package fmmu_pkg;

   localparam int START_W = 9;
   localparam int COUNT_W = 10;
   localparam int ADDR_W  = 32;
   localparam int LIMIT_W = 10;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_MAP       = 2'd0,
      OP_UNMAP     = 2'd1,
      OP_TRANSLATE = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DBUS_LOW    = 3'd0,
      CSR_DBUS_HIGH   = 3'd1,
      CSR_IBUS_LOW    = 3'd2,
      CSR_IBUS_HIGH   = 3'd3,
      CSR_OFFSET_MASK = 3'd4,
      CSR_ENTRY_LIMIT = 3'd5
   } csr_index_type;

   localparam logic [ADDR_W-1:0]  DBUS_LOW_RST    = 32'h3C00_0000;
   localparam logic [ADDR_W-1:0]  DBUS_HIGH_RST   = 32'h3E00_0000;
   localparam logic [ADDR_W-1:0]  IBUS_LOW_RST    = 32'h4200_0000;
   localparam logic [ADDR_W-1:0]  IBUS_HIGH_RST   = 32'h4400_0000;
   localparam logic [ADDR_W-1:0]  OFFSET_MASK_RST = 32'h01FF_FFFF;
   localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST = 10'd256;

   typedef struct packed {
      logic [ADDR_W-1:0]  dbus_window_low;
      logic [ADDR_W-1:0]  dbus_window_high;
      logic [ADDR_W-1:0]  ibus_window_low;
      logic [ADDR_W-1:0]  ibus_window_high;
      logic [ADDR_W-1:0]  window_offset_mask;
      logic [LIMIT_W-1:0] flash_entry_limit;
   } csr_type;

   typedef struct packed {
      logic               ok;
      logic [START_W-1:0] start_entry;
      logic [COUNT_W-1:0] entry_count;
      logic [ADDR_W-1:0]  mapped_address;
      logic [ADDR_W-1:0]  byte_offset;
   } result_type;

   typedef enum logic [8:0] {
      S_CLEAR     = 9'b000000001,
      S_IDLE      = 9'b000000010,
      S_MAP_SCAN  = 9'b000000100,
      S_MAP_CHECK = 9'b000001000,
      S_MAP_WRITE = 9'b000010000,
      S_UNMAP     = 9'b000100000,
      S_TR_READ   = 9'b001000000,
      S_TR_CHECK  = 9'b010000000,
      S_DONE      = 9'b100000000
   } state_type;

endpackage

// ===== design/fmmu_csr.sv =====
module fmmu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fmmu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fmmu_pkg::ADDR_W-1:0]         csr_wdata,
   output fmmu_pkg::csr_type                   csr_cfg
);

   fmmu_pkg::csr_type cfg_ff;
   fmmu_pkg::csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            fmmu_pkg::CSR_DBUS_LOW:    cfg_in.dbus_window_low    = csr_wdata;
            fmmu_pkg::CSR_DBUS_HIGH:   cfg_in.dbus_window_high   = csr_wdata;
            fmmu_pkg::CSR_IBUS_LOW:    cfg_in.ibus_window_low    = csr_wdata;
            fmmu_pkg::CSR_IBUS_HIGH:   cfg_in.ibus_window_high   = csr_wdata;
            fmmu_pkg::CSR_OFFSET_MASK: cfg_in.window_offset_mask = csr_wdata;
            fmmu_pkg::CSR_ENTRY_LIMIT: begin
               cfg_in.flash_entry_limit = csr_wdata[fmmu_pkg::LIMIT_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dbus_window_low    <= fmmu_pkg::DBUS_LOW_RST;
         cfg_ff.dbus_window_high   <= fmmu_pkg::DBUS_HIGH_RST;
         cfg_ff.ibus_window_low    <= fmmu_pkg::IBUS_LOW_RST;
         cfg_ff.ibus_window_high   <= fmmu_pkg::IBUS_HIGH_RST;
         cfg_ff.window_offset_mask <= fmmu_pkg::OFFSET_MASK_RST;
         cfg_ff.flash_entry_limit  <= fmmu_pkg::ENTRY_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_cfg = cfg_ff;

endmodule

// ===== design/flash_mmu_page_table.sv =====
// Flash MMU page table: one request in, one response out, one request in flight at a time.
// The table sits in a synchronous memory of ENTRY_COUNT entries, one write and one
// registered read port, one access per cycle. After reset a clearing pass writes the
// invalid marker to every entry, with req_ready low. A translate reads one entry, and
// skips the read when the address misses the windows or the table. A map scans the
// entries up to the first free one (at most the flash limit) and then writes the
// entries it maps. An unmap invalidates the requested entries inside the table. A
// request of an unused kind goes straight to the response.
// A finished response waits in an output register, so a new request is taken meanwhile.
module flash_mmu_page_table #(
   parameter int ENTRY_COUNT     = 512,
   parameter int PAGE_BITS       = 16,
   parameter int ENTRY_WIDTH     = 16,
   parameter int INVALID_BIT     = 14,
   parameter int SPIRAM_BIT      = 15,
   parameter int PAGE_FIELD_BITS = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [fmmu_pkg::ADDR_W-1:0]        req_src_addr,
   input  logic [fmmu_pkg::ADDR_W-1:0]        req_map_size,
   input  logic [fmmu_pkg::START_W-1:0]       req_unmap_start,
   input  logic [fmmu_pkg::COUNT_W-1:0]       req_unmap_count,
   input  logic [fmmu_pkg::ADDR_W-1:0]        req_bus_address,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ok,
   output logic [fmmu_pkg::START_W-1:0]       rsp_start_entry,
   output logic [fmmu_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic [fmmu_pkg::ADDR_W-1:0]        rsp_mapped_address,
   output logic [fmmu_pkg::ADDR_W-1:0]        rsp_byte_offset,
   input  logic                               csr_we,
   input  logic [fmmu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fmmu_pkg::ADDR_W-1:0]        csr_wdata
);

   localparam int IDX_W   = $clog2(ENTRY_COUNT);
   localparam int CNT_W   = $clog2(ENTRY_COUNT + 1);
   localparam int CF_W    = 34 - PAGE_BITS;
   localparam int UM_W    = (IDX_W > fmmu_pkg::COUNT_W) ? IDX_W : fmmu_pkg::COUNT_W;
   localparam int PAGE_W  = 32 - PAGE_BITS;
   localparam int START_W = fmmu_pkg::START_W;
   localparam int COUNT_W = fmmu_pkg::COUNT_W;
   localparam logic [ENTRY_WIDTH-1:0] INV_MARK = ENTRY_WIDTH'(32'd1 << INVALID_BIT);
   localparam logic [31:0] BAD_MASK   = (32'd1 << INVALID_BIT) | (32'd1 << SPIRAM_BIT);
   localparam logic [31:0] FIELD_MASK = 32'((64'd1 << PAGE_FIELD_BITS) - 64'd1);
   localparam logic [31:0] PAGE_MASK  = 32'((64'd1 << PAGE_BITS) - 64'd1);

   fmmu_pkg::csr_type    csr_cfg;
   fmmu_pkg::state_type  state_ff, state_in;
   fmmu_pkg::result_type res_ff, res_in;
   fmmu_pkg::result_type out_ff, out_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [31:0]            src_ff, bus_ff;
   logic [CF_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [IDX_W-1:0]       chk_ff, chk_in;
   logic                   pend_ff, pend_in;
   logic [CNT_W-1:0]       start_ff, start_in;
   logic [IDX_W-1:0]       widx_ff, widx_in;
   logic [CNT_W-1:0]       wleft_ff, wleft_in;
   logic [ENTRY_WIDTH-1:0] wdata_ff, wdata_in;
   logic [UM_W-1:0]        um_idx_ff, um_idx_in;
   logic [COUNT_W-1:0]     um_left_ff, um_left_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;

   logic [ENTRY_WIDTH-1:0] page_table_ff [ENTRY_COUNT];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [ENTRY_WIDTH-1:0] mem_wdata;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;

   logic                   req_xfer;
   logic [CNT_W-1:0]       lim;
   logic [31:0]            ent32;
   logic [33:0]            cnt_sum;
   logic [39:0]            end_sum;
   logic [PAGE_W-1:0]      tr_page;
   logic                   win_bad;

   fmmu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_cfg   (csr_cfg)
   );

   assign req_ready = (state_ff == fmmu_pkg::S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   assign lim = (32'(csr_cfg.flash_entry_limit) > 32'(ENTRY_COUNT)) ?
                CNT_W'(ENTRY_COUNT) : CNT_W'(csr_cfg.flash_entry_limit);
   assign ent32   = 32'(rd_data_ff);
   assign cnt_sum = 34'(req_src_addr & PAGE_MASK) + 34'(req_map_size) + 34'(PAGE_MASK);
   assign end_sum = 40'(start_ff) + 40'(cnt_ff);
   assign tr_page = PAGE_W'((bus_ff & csr_cfg.window_offset_mask) >> PAGE_BITS);
   assign win_bad = (bus_ff < csr_cfg.dbus_window_low) ||
                    (bus_ff >= csr_cfg.ibus_window_high) ||
                    ((bus_ff >= csr_cfg.dbus_window_high) &&
                     (bus_ff < csr_cfg.ibus_window_low));

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      pend_in      = pend_ff;
      start_in     = start_ff;
      widx_in      = widx_ff;
      wleft_in     = wleft_ff;
      wdata_in     = wdata_ff;
      um_idx_in    = um_idx_ff;
      um_left_in   = um_left_ff;
      clr_in       = clr_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         fmmu_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = INV_MARK;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(ENTRY_COUNT - 1)) begin
               state_in = fmmu_pkg::S_IDLE;
            end
         end
         fmmu_pkg::S_IDLE: begin
            if (req_xfer) begin
               res_in = '0;
               unique case (req_opcode)
                  fmmu_pkg::OP_MAP: begin
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     state_in = fmmu_pkg::S_MAP_SCAN;
                  end
                  fmmu_pkg::OP_UNMAP: begin
                     res_in.ok  = 1'b1;
                     um_idx_in  = UM_W'(req_unmap_start);
                     um_left_in = req_unmap_count;
                     state_in   = fmmu_pkg::S_UNMAP;
                  end
                  fmmu_pkg::OP_TRANSLATE: begin
                     state_in = fmmu_pkg::S_TR_READ;
                  end
                  default: begin
                     state_in = fmmu_pkg::S_DONE;
                  end
               endcase
            end
         end
         fmmu_pkg::S_MAP_SCAN: begin
            priority if (pend_ff && ent32[INVALID_BIT]) begin
               start_in = CNT_W'(chk_ff);
               state_in = fmmu_pkg::S_MAP_CHECK;
            end else if (scan_ff >= lim) begin
               start_in = lim;
               state_in = fmmu_pkg::S_MAP_CHECK;
            end else begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(scan_ff);
               chk_in  = IDX_W'(scan_ff);
               pend_in = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         fmmu_pkg::S_MAP_CHECK: begin
            if (end_sum < 40'(lim)) begin
               res_in.ok             = 1'b1;
               res_in.start_entry    = START_W'(start_ff);
               res_in.entry_count    = COUNT_W'(cnt_ff);
               res_in.mapped_address = csr_cfg.dbus_window_low +
                                       (32'(64'(start_ff) << PAGE_BITS) | (src_ff & PAGE_MASK));
               widx_in  = IDX_W'(start_ff);
               wleft_in = CNT_W'(cnt_ff);
               wdata_in = ENTRY_WIDTH'(64'(src_ff) >> PAGE_BITS);
               state_in = (cnt_ff == '0) ? fmmu_pkg::S_DONE : fmmu_pkg::S_MAP_WRITE;
            end else begin
               state_in = fmmu_pkg::S_DONE;
            end
         end
         fmmu_pkg::S_MAP_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = widx_ff;
            mem_wdata = wdata_ff;
            widx_in   = widx_ff + IDX_W'(1);
            wdata_in  = wdata_ff + ENTRY_WIDTH'(1);
            wleft_in  = wleft_ff - CNT_W'(1);
            if (wleft_ff == CNT_W'(1)) begin
               state_in = fmmu_pkg::S_DONE;
            end
         end
         fmmu_pkg::S_UNMAP: begin
            if ((um_left_ff == '0) || (32'(um_idx_ff) >= 32'(ENTRY_COUNT))) begin
               state_in = fmmu_pkg::S_DONE;
            end else begin
               mem_we     = 1'b1;
               mem_waddr  = IDX_W'(um_idx_ff);
               mem_wdata  = INV_MARK;
               um_idx_in  = um_idx_ff + UM_W'(1);
               um_left_in = um_left_ff - COUNT_W'(1);
            end
         end
         fmmu_pkg::S_TR_READ: begin
            if (win_bad || (32'(tr_page) >= 32'(ENTRY_COUNT))) begin
               state_in = fmmu_pkg::S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(tr_page);
               state_in = fmmu_pkg::S_TR_CHECK;
            end
         end
         fmmu_pkg::S_TR_CHECK: begin
            if ((ent32 & BAD_MASK) == '0) begin
               res_in.ok          = 1'b1;
               res_in.byte_offset = 32'(64'(ent32 & FIELD_MASK) << PAGE_BITS) |
                                    (bus_ff & PAGE_MASK);
            end
            state_in = fmmu_pkg::S_DONE;
         end
         fmmu_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = fmmu_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fmmu_pkg::S_IDLE;
         end
      endcase
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_table_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= page_table_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmmu_pkg::S_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         src_ff <= req_src_addr;
         bus_ff <= req_bus_address;
         cnt_ff <= CF_W'(cnt_sum >> PAGE_BITS);
      end
      res_ff     <= res_in;
      out_ff     <= out_in;
      chk_ff     <= chk_in;
      start_ff   <= start_in;
      widx_ff    <= widx_in;
      wleft_ff   <= wleft_in;
      wdata_ff   <= wdata_in;
      um_idx_ff  <= um_idx_in;
      um_left_ff <= um_left_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = out_ff.ok;
   assign rsp_start_entry    = out_ff.start_entry;
   assign rsp_entry_count    = out_ff.entry_count;
   assign rsp_mapped_address = out_ff.mapped_address;
   assign rsp_byte_offset    = out_ff.byte_offset;

endmodule

// ===== design/fmmu_checker.sv =====
module fmmu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [1:0]                         req_opcode,
   input logic [fmmu_pkg::ADDR_W-1:0]        req_src_addr,
   input logic [fmmu_pkg::ADDR_W-1:0]        req_map_size,
   input logic [fmmu_pkg::START_W-1:0]       req_unmap_start,
   input logic [fmmu_pkg::COUNT_W-1:0]       req_unmap_count,
   input logic [fmmu_pkg::ADDR_W-1:0]        req_bus_address,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_ok,
   input logic [fmmu_pkg::START_W-1:0]       rsp_start_entry,
   input logic [fmmu_pkg::COUNT_W-1:0]       rsp_entry_count,
   input logic [fmmu_pkg::ADDR_W-1:0]        rsp_mapped_address,
   input logic [fmmu_pkg::ADDR_W-1:0]        rsp_byte_offset,
   input logic                               csr_we,
   input logic [fmmu_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [fmmu_pkg::ADDR_W-1:0]        csr_wdata
);

   // clearing pass holds off requests right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request or response open right after reset");

   // a stalled response transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
         $stable(rsp_start_entry) && $stable(rsp_entry_count) &&
         $stable(rsp_mapped_address) && $stable(rsp_byte_offset))
      else $error("stalled response changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_start_entry == '0 && rsp_entry_count == '0 &&
         rsp_mapped_address == '0 && rsp_byte_offset == '0)
      else $error("failed response carries nonzero fields");

   // translate results never carry map fields
   a_translate_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_offset != '0 |-> rsp_ok && rsp_start_entry == '0 &&
         rsp_entry_count == '0 && rsp_mapped_address == '0)
      else $error("byte offset mixed with map fields");

endmodule

bind flash_mmu_page_table fmmu_checker u_fmmu_checker (.*);
